>>> hdl/bkss_pkg.sv
// ----------------------------------------------------------------------------
// bkss_pkg: shared types and constants
// Holds the opcode and status codes, the fixed port widths and the default
// sizes for the bounded key stack.
// ----------------------------------------------------------------------------
package bkss_pkg;

    localparam int unsigned KEY_BITS        = 64;
    localparam int unsigned COUNT_BITS      = 4;
    localparam int unsigned DEPTH_DEFAULT   = 8;
    localparam int unsigned KEY_WIDTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

>>> hdl/bkss_ram.sv
// ----------------------------------------------------------------------------
// bkss_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bkss_ram
    import bkss_pkg::*;
#(
    parameter int unsigned WIDTH = KEY_WIDTH_DEFAULT,
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AddrW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/bounded_key_stack_search_remove.sv
// ----------------------------------------------------------------------------
// bounded_key_stack_search_remove: LIFO key store with search and remove
// Push, pop, search and remove-topmost-match over a RAM-held key stack,
// driven by a small sequencer around a single key comparator.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Requests are handled one at a
// time: in_stall stays high from acceptance until the result has been moved
// into the output register, which then holds it until taken, so the next
// request may be accepted while a result still waits. The keys live in a RAM
// with one write and one registered read port; every entry visited is read
// through that port. A push writes the key at the top; a pop reads the top
// entry; a search scans entries from the top downwards until a match or the
// bottom entry, and a remove then shifts every entry above the match down one
// place. A pop, search or remove on an empty stack finishes without reading
// the RAM. While the output register still holds an untaken word, the
// result waits before it is handed over. Only the low KEY_WIDTH bits of
// key_in are stored and compared; key_out is zero-extended to 64 bits.
// ----------------------------------------------------------------------------
module bounded_key_stack_search_remove
    import bkss_pkg::*;
#(
    parameter int unsigned DEPTH     = DEPTH_DEFAULT,
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [KEY_BITS-1:0]   key_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_BITS-1:0]   key_out,
    output logic [1:0]            status,
    output logic                  found,
    output logic [COUNT_BITS-1:0] entry_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_POPRD  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;

    // Result being built up for the current word
    status_t               res_status_reg, res_status_next;
    logic                  res_found_reg, res_found_next;
    logic [KEY_WIDTH-1:0]  res_key_reg, res_key_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_found_reg, out_found_next;
    logic [KEY_WIDTH-1:0]  out_key_reg, out_key_next;
    logic [CW-1:0]         out_count_reg, out_count_next;

    // RAM port signals
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [KEY_WIDTH-1:0]  wr_data;
    logic [AW-1:0]         rd_addr;
    logic [KEY_WIDTH-1:0]  rd_data;

    logic                  in_take;
    logic                  out_free;
    logic                  key_match;
    logic                  is_empty;
    logic                  is_full;
    logic                  above_one;
    logic                  above_two;

    bkss_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // The shared comparator: one stored key against the request key per cycle
    assign key_match = (rd_data == key_reg);

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    // Entries above the current index still inside the stack
    assign above_one = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) < (CW + 1)'(count_reg);
    assign above_two = ((CW + 1)'(idx_reg) + (CW + 1)'(2)) < (CW + 1)'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_key_next    = res_key_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_key_next    = out_key_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        rd_addr         = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the request word and clear the result
                if (in_take)
                begin
                    op_next         = op_t'(opcode);
                    key_next        = key_in[KEY_WIDTH-1:0];
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_key_next    = '0;
                    state_next      = S_START;
                end
            end

            S_START:
            begin
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(count_reg);
                            wr_data    = key_reg;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    OP_POP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            rd_addr    = AW'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = S_POPRD;
                        end
                    end
                    OP_SEARCH,
                    OP_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = (op_reg == OP_REMOVE) ? ST_EMPTY
                                                                    : ST_NOT_FOUND;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            // Scan from the top entry downwards
                            rd_addr    = AW'(count_reg - 1'b1);
                            idx_next   = AW'(count_reg - 1'b1);
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_POPRD:
            begin
                res_key_next = rd_data;
                state_next   = S_FINISH;
            end

            S_SCAN:
            begin
                if (key_match)
                begin
                    res_found_next = 1'b1;
                    if (op_reg == OP_REMOVE && above_one)
                    begin
                        rd_addr    = idx_reg + 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        if (op_reg == OP_REMOVE)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Move the entry above down into the current slot
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = idx_reg + 1'b1;
                if (above_two)
                begin
                    rd_addr = AW'((CW + 1)'(idx_reg) + (CW + 1)'(2));
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_key_next    = res_key_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_key_reg    <= res_key_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_key_reg    <= out_key_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_out     = KEY_BITS'(out_key_reg);
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign entry_count = COUNT_BITS'(out_count_reg);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_START)
        else $error("accepted word did not start the sequencer");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FULL) |-> out_count_reg == CW'(DEPTH))
        else $error("full reported below depth");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |-> out_status_reg == ST_OK)
        else $error("found flagged with a failing status");

    a_key_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> out_key_reg == '0)
        else $error("key returned on a failed request");
`endif

endmodule
